// File: rtl/core/rarm_pkg.sv
package rarm_pkg;

   // Operation carried in the kind field of a request beat
   localparam logic KIND_ADD = 1'b0;
   localparam logic KIND_MUL = 1'b1;

   // Class given to a job by the front end
   typedef logic [1:0] cls_type;

   localparam cls_type CLS_ADD  = 2'd0;  // full add path
   localparam cls_type CLS_MUL  = 2'd1;  // full multiply path
   localparam cls_type CLS_ZDEN = 2'd2;  // a denominator is zero: result 0/0
   localparam cls_type CLS_ZNUM = 2'd3;  // multiply by zero numerator: result 0/1

   localparam int unsigned RES_NUM_W = 32;
   localparam int unsigned RES_DEN_W = 31;

endpackage

// File: rtl/core/rarm_req_if.sv
interface rarm_req_if #(
   parameter int WIDTH = 16
);
   logic                    valid;
   logic                    ready;
   logic                    kind;
   logic signed [WIDTH-1:0] a_num;
   logic [WIDTH-2:0]        a_den;
   logic signed [WIDTH-1:0] b_num;
   logic [WIDTH-2:0]        b_den;

   modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

// File: rtl/core/rarm_rsp_if.sv
interface rarm_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [rarm_pkg::RES_NUM_W-1:0]  res_num;
   logic [rarm_pkg::RES_DEN_W-1:0]         res_den;

   modport source (output valid, res_num, res_den, input ready);
   modport sink   (input valid, res_num, res_den, output ready);
endinterface

// File: rtl/core/rarm_fifo.sv
module rarm_fifo #(
   parameter int DW    = 64,
   parameter int DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  logic [DW-1:0] push_data,
   output logic          pop_valid,
   input  logic          pop_ready,
   output logic [DW-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          push, pop;

   assign push_ready = (cnt_ff != CW'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = mem_ff[rd_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/rarm_front.sv
module rarm_front #(
   parameter int WIDTH = 16,
   parameter int JW    = 4 * 16
) (
   rarm_req_if.sink        req_ch,
   output logic            push_valid,
   input  logic            push_ready,
   output logic [JW-1:0]   push_data
);

   typedef struct packed {
      rarm_pkg::cls_type       cls;
      logic signed [WIDTH-1:0] a_num;
      logic [WIDTH-2:0]        a_den;
      logic signed [WIDTH-1:0] b_num;
      logic [WIDTH-2:0]        b_den;
   } job_type;

   job_type job;

   // sort the beat into a class so trivial cases skip the arithmetic
   always_comb begin
      job.a_num = req_ch.a_num;
      job.a_den = req_ch.a_den;
      job.b_num = req_ch.b_num;
      job.b_den = req_ch.b_den;
      priority if (req_ch.a_den == '0 || req_ch.b_den == '0) begin
         job.cls = rarm_pkg::CLS_ZDEN;
      end else if (req_ch.kind && (req_ch.a_num == '0 || req_ch.b_num == '0)) begin
         job.cls = rarm_pkg::CLS_ZNUM;
      end else if (req_ch.kind) begin
         job.cls = rarm_pkg::CLS_MUL;
      end else begin
         job.cls = rarm_pkg::CLS_ADD;
      end
   end

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;
   assign push_data    = JW'(job);

endmodule

// File: rtl/core/rarm_back.sv
module rarm_back #(
   parameter int WIDTH = 16,
   parameter int JW    = 4 * 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  logic [JW-1:0] pop_data,
   rarm_rsp_if.source    rsp_ch
);

   localparam int MW = 2 * WIDTH;           // magnitude width
   localparam int NW = 2 * WIDTH + 1;       // signed raw numerator width
   localparam int RW = (MW > 32) ? MW : 32; // width for output truncation
   localparam int SW = $clog2(MW + 1);
   localparam int CW = $clog2(MW);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL1  = 4'd1;
   localparam logic [3:0] ST_MUL2  = 4'd2;
   localparam logic [3:0] ST_MUL3  = 4'd3;
   localparam logic [3:0] ST_CHECK = 4'd4;
   localparam logic [3:0] ST_ABS   = 4'd5;
   localparam logic [3:0] ST_TWOS  = 4'd6;
   localparam logic [3:0] ST_XODD  = 4'd7;
   localparam logic [3:0] ST_LOOP  = 4'd8;
   localparam logic [3:0] ST_DIV   = 4'd9;
   localparam logic [3:0] ST_SIGN  = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   typedef struct packed {
      rarm_pkg::cls_type       cls;
      logic signed [WIDTH-1:0] a_num;
      logic [WIDTH-2:0]        a_den;
      logic signed [WIDTH-1:0] b_num;
      logic [WIDTH-2:0]        b_den;
   } job_type;

   logic [3:0]                            state_ff, state_in;
   job_type                               job_ff, job_in;
   logic signed [MW-1:0]                  p1_ff, p1_in;
   logic signed [MW-1:0]                  p2_ff, p2_in;
   logic [MW-1:0]                         den_ff, den_in;
   logic signed [NW-1:0]                  num_ff, num_in;
   logic                                  neg_ff, neg_in;
   logic [MW-1:0]                         x_ff, x_in;
   logic [MW-1:0]                         y_ff, y_in;
   logic [SW-1:0]                         sh_ff, sh_in;
   logic [MW-1:0]                         div_ff, div_in;
   logic [MW-1:0]                         qn_ff, qn_in;
   logic [MW-1:0]                         qd_ff, qd_in;
   logic [MW-1:0]                         rn_ff, rn_in;
   logic [MW-1:0]                         rd_ff, rd_in;
   logic [CW-1:0]                         cnt_ff, cnt_in;
   logic signed [rarm_pkg::RES_NUM_W-1:0] res_num_ff, res_num_in;
   logic [rarm_pkg::RES_DEN_W-1:0]        res_den_ff, res_den_in;
   logic                                  out_valid_ff, out_valid_in;
   logic signed [rarm_pkg::RES_NUM_W-1:0] out_num_ff, out_num_in;
   logic [rarm_pkg::RES_DEN_W-1:0]        out_den_ff, out_den_in;

   job_type              job_pop;
   logic signed [WIDTH-1:0] mul_a, mul_b;
   logic signed [MW-1:0] prod;
   logic signed [NW-1:0] num_neg;
   logic [MW:0]          dxy, dyx;
   logic [MW:0]          trn, trd;
   logic [RW-1:0]        q_ext, q_sgn, d_ext;
   logic                 out_free;

   assign job_pop   = job_type'(pop_data);
   assign pop_ready = (state_ff == ST_IDLE);
   assign out_free  = !out_valid_ff || rsp_ch.ready;

   // shared multiplier, one product per cycle
   always_comb begin
      unique case (state_ff)
         ST_MUL1: begin
            mul_a = job_ff.a_num;
            mul_b = (job_ff.cls == rarm_pkg::CLS_MUL) ? job_ff.b_num
                                                      : $signed({1'b0, job_ff.b_den});
         end
         ST_MUL2: begin
            mul_a = job_ff.b_num;
            mul_b = $signed({1'b0, job_ff.a_den});
         end
         default: begin
            mul_a = $signed({1'b0, job_ff.a_den});
            mul_b = $signed({1'b0, job_ff.b_den});
         end
      endcase
   end

   assign prod    = mul_a * mul_b;
   assign num_neg = -num_ff;
   assign dxy     = {1'b0, x_ff} - {1'b0, y_ff};
   assign dyx     = {1'b0, y_ff} - {1'b0, x_ff};
   assign trn     = {rn_ff, qn_ff[MW-1]};
   assign trd     = {rd_ff, qd_ff[MW-1]};
   assign q_ext   = RW'(qn_ff);
   assign q_sgn   = neg_ff ? (~q_ext + 1'b1) : q_ext;
   assign d_ext   = RW'(qd_ff);

   // sequencer: multiply, sum, binary gcd, restoring divide, sign
   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      p1_in      = p1_ff;
      p2_in      = p2_ff;
      den_in     = den_ff;
      num_in     = num_ff;
      neg_in     = neg_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      sh_in      = sh_ff;
      div_in     = div_ff;
      qn_in      = qn_ff;
      qd_in      = qd_ff;
      rn_in      = rn_ff;
      rd_in      = rd_ff;
      cnt_in     = cnt_ff;
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               job_in = job_pop;
               unique case (job_pop.cls)
                  rarm_pkg::CLS_ZDEN: begin
                     res_num_in = '0;
                     res_den_in = '0;
                     state_in   = ST_DONE;
                  end
                  rarm_pkg::CLS_ZNUM: begin
                     res_num_in = '0;
                     res_den_in = rarm_pkg::RES_DEN_W'(1);
                     state_in   = ST_DONE;
                  end
                  default: state_in = ST_MUL1;
               endcase
            end
         end
         ST_MUL1: begin
            p1_in    = prod;
            state_in = (job_ff.cls == rarm_pkg::CLS_MUL) ? ST_MUL3 : ST_MUL2;
         end
         ST_MUL2: begin
            p2_in    = prod;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            den_in   = $unsigned(prod);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            num_in   = (job_ff.cls == rarm_pkg::CLS_MUL) ? NW'(p1_ff)
                                                         : NW'(p1_ff) + NW'(p2_ff);
            state_in = ST_ABS;
         end
         ST_ABS: begin
            if (num_ff == '0) begin
               res_num_in = '0;
               res_den_in = rarm_pkg::RES_DEN_W'(1);
               state_in   = ST_DONE;
            end else begin
               neg_in   = num_ff[NW-1];
               x_in     = num_ff[NW-1] ? num_neg[MW-1:0] : num_ff[MW-1:0];
               qn_in    = num_ff[NW-1] ? num_neg[MW-1:0] : num_ff[MW-1:0];
               y_in     = den_ff;
               qd_in    = den_ff;
               sh_in    = '0;
               state_in = ST_TWOS;
            end
         end
         ST_TWOS: begin
            // strip common factors of two
            if (x_ff[0] || y_ff[0]) begin
               state_in = ST_XODD;
            end else begin
               x_in  = x_ff >> 1;
               y_in  = y_ff >> 1;
               sh_in = sh_ff + 1'b1;
            end
         end
         ST_XODD: begin
            if (x_ff[0]) begin
               state_in = ST_LOOP;
            end else begin
               x_in = x_ff >> 1;
            end
         end
         ST_LOOP: begin
            priority if (y_ff == '0) begin
               div_in   = x_ff << sh_ff;
               rn_in    = '0;
               rd_in    = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (!dxy[MW] && dxy != '0) begin
               // x > y: swap and subtract
               x_in = y_ff;
               y_in = dxy[MW-1:0];
            end else begin
               y_in = dyx[MW-1:0];
            end
         end
         ST_DIV: begin
            // one quotient bit per cycle for both numerator and denominator
            if (trn >= {1'b0, div_ff}) begin
               rn_in = MW'(trn - {1'b0, div_ff});
               qn_in = {qn_ff[MW-2:0], 1'b1};
            end else begin
               rn_in = trn[MW-1:0];
               qn_in = {qn_ff[MW-2:0], 1'b0};
            end
            if (trd >= {1'b0, div_ff}) begin
               rd_in = MW'(trd - {1'b0, div_ff});
               qd_in = {qd_ff[MW-2:0], 1'b1};
            end else begin
               rd_in = trd[MW-1:0];
               qd_in = {qd_ff[MW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(MW - 1)) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            res_num_in = q_sgn[rarm_pkg::RES_NUM_W-1:0];
            res_den_in = d_ext[rarm_pkg::RES_DEN_W-1:0];
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_num_in   = out_num_ff;
      out_den_in   = out_den_ff;
      if (state_ff == ST_DONE && out_free) begin
         out_valid_in = 1'b1;
         out_num_in   = res_num_ff;
         out_den_in   = res_den_ff;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
      den_ff     <= den_in;
      num_ff     <= num_in;
      neg_ff     <= neg_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      sh_ff      <= sh_in;
      div_ff     <= div_in;
      qn_ff      <= qn_in;
      qd_ff      <= qd_in;
      rn_ff      <= rn_in;
      rd_ff      <= rd_in;
      cnt_ff     <= cnt_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.res_num = out_num_ff;
   assign rsp_ch.res_den = out_den_ff;

   // gcd loop keeps x odd
   a_x_odd: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOP |-> x_ff[0])
      else $error("gcd loop entered with even x");

   // divisor is never zero
   a_div_nz: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> div_ff != '0)
      else $error("division by zero gcd");

   // gcd divides both terms exactly
   a_exact: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SIGN |-> (rn_ff == '0 && rd_ff == '0))
      else $error("nonzero remainder after reduction");

   // output beat is only replaced once taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |=> out_valid_ff && $stable(out_num_ff))
      else $error("pending result overwritten");

endmodule

// File: rtl/core/rational_add_multiply_reduce_top.sv
// Rational add/multiply with reduction to lowest terms. Each request beat carries two
// fractions (signed numerator, positive denominator) and an operation bit (0 add,
// 1 multiply); each produces one response beat with the fraction divided by the gcd of
// the magnitudes, the sign on the numerator, 0/1 for a zero numerator and 0/0 when a
// denominator is zero. A two-entry queue sits between the request side and the
// arithmetic engine, and the response has its own output register. The engine handles
// one beat at a time: the idle state takes it from the queue, the shared multiplier
// forms two products for a multiply or three for an add, the check and abs states sum and
// take the magnitude, a binary gcd does one shift or subtract per cycle (every subtract is
// followed by a shift and every shift drops a bit), then a bit-serial restoring divide
// runs for numerator and denominator together, and a sign step and a done state finish.
// A zero denominator or a multiply by zero goes straight from the queue to the done
// state, and a zero sum goes there from the magnitude step. No clearing pass.
module rational_add_multiply_reduce_top #(
   parameter int WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   rarm_req_if.sink    req_ch,
   rarm_rsp_if.source  rsp_ch
);

   localparam int JW = $bits(rarm_pkg::cls_type) + 4 * WIDTH - 2;

   logic          push_valid, push_ready;
   logic [JW-1:0] push_data;
   logic          pop_valid, pop_ready;
   logic [JW-1:0] pop_data;

   rarm_front #(.WIDTH(WIDTH), .JW(JW)) u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   rarm_fifo #(.DW(JW), .DEPTH(2)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   rarm_back #(.WIDTH(WIDTH), .JW(JW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

endmodule

// File: tb/rarm_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels. Every request beat is reduced here as well, and the
// resulting fraction waits in order until the matching response beat arrives.
module rarm_result_checker #(
   parameter int WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   rarm_req_if         req_mon,
   rarm_rsp_if         rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned fractions_pending
);

   typedef struct packed {
      logic signed [rarm_pkg::RES_NUM_W-1:0] num;
      logic [rarm_pkg::RES_DEN_W-1:0]        den;
   } fraction_type;

   fraction_type expected_fractions[$];

   // Euclid on the magnitudes; both arguments are nonzero here
   function automatic longint unsigned magnitude_gcd(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // Sum or product of two fractions, brought to lowest terms
   function automatic fraction_type reduce_sum_or_product(
      logic                    kind,
      logic signed [WIDTH-1:0] a_num,
      logic [WIDTH-2:0]        a_den,
      logic signed [WIDTH-1:0] b_num,
      logic [WIDTH-2:0]        b_den
   );
      longint       n1, n2, d1, d2, num, den, mag;
      longint       g;
      fraction_type f;
      n1 = a_num;
      n2 = b_num;
      d1 = a_den;
      d2 = b_den;
      den = d1 * d2;
      num = (kind == rarm_pkg::KIND_MUL) ? n1 * n2 : n1 * d2 + n2 * d1;
      f = '0;
      // zero denominator: 0/0 flags the result as invalid
      if (den == 0)
         return f;
      if (num == 0) begin
         f.den = rarm_pkg::RES_DEN_W'(1);
         return f;
      end
      mag = (num < 0) ? -num : num;
      g = longint'(magnitude_gcd(mag, den));
      mag = mag / g;
      den = den / g;
      num = (num < 0) ? -mag : mag;
      f.num = num[rarm_pkg::RES_NUM_W-1:0];
      f.den = den[rarm_pkg::RES_DEN_W-1:0];
      return f;
   endfunction

   // Predict on request beats, compare on response beats
   always @(posedge clock) begin : watch
      fraction_type want;
      int           bad;
      bad = 0;
      if (reset) begin
         expected_fractions.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_fractions.push_back(reduce_sum_or_product(req_mon.kind, req_mon.a_num,
               req_mon.a_den, req_mon.b_num, req_mon.b_den));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_fractions.size() == 0) begin
               $error("unexpected response beat %0d/%0d", $signed(rsp_mon.res_num),
                  rsp_mon.res_den);
               bad++;
            end else begin
               want = expected_fractions.pop_front();
               if (rsp_mon.res_num !== want.num) begin
                  $error("res_num: expected %0d, got %0d", $signed(want.num),
                     $signed(rsp_mon.res_num));
                  bad++;
               end
               if (rsp_mon.res_den !== want.den) begin
                  $error("res_den: expected %0d, got %0d", want.den, rsp_mon.res_den);
                  bad++;
               end
            end
         end
      end
      mismatch_count    <= mismatch_count + bad;
      fractions_pending <= expected_fractions.size();
   end

endmodule

// File: tb/rational_add_multiply_reduce_top_test.sv
`timescale 1ns / 1ps

module rational_add_multiply_reduce_top_test;

   localparam int WIDTH        = 16;
   localparam int RANDOM_ITEMS = 750;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 300;

   typedef logic signed [WIDTH-1:0] num_type;
   typedef logic [WIDTH-2:0]        den_type;

   localparam logic    OP_ADD  = rarm_pkg::KIND_ADD;
   localparam logic    OP_MUL  = rarm_pkg::KIND_MUL;
   localparam num_type NUM_MIN = {1'b1, {(WIDTH-1){1'b0}}};
   localparam num_type NUM_MAX = {1'b0, {(WIDTH-1){1'b1}}};
   localparam den_type DEN_MAX = '1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int unsigned mismatch_count;
   int unsigned fractions_pending;
   int unsigned cycle_count = 0;
   int unsigned ready_hold = 0;
   bit          steady = 1'b0;

   rarm_req_if #(.WIDTH(WIDTH)) req_ch ();
   rarm_rsp_if                  rsp_ch ();

   rational_add_multiply_reduce_top #(.WIDTH(WIDTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rarm_result_checker #(.WIDTH(WIDTH)) fraction_check (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_ch),
      .rsp_mon           (rsp_ch),
      .mismatch_count    (mismatch_count),
      .fractions_pending (fractions_pending)
   );

   always #5 clock = ~clock;

   // Idle length: mostly none or short, now and then long
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 20);
      return $urandom_range(40, 250);
   endfunction

   function automatic num_type pick_num();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return NUM_MIN;
      if (r < 6) return NUM_MAX;
      if (r < 9) return '0;
      if (r < 35) return num_type'(int'($urandom_range(0, 128)) - 64);
      return num_type'($urandom);
   endfunction

   function automatic den_type pick_den();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return '0;
      if (r < 6) return DEN_MAX;
      if (r < 30) return den_type'($urandom_range(1, 64));
      return den_type'($urandom_range(1, 32767));
   endfunction

   // Response side stalls
   always @(posedge clock) begin
      if (steady) begin
         rsp_ch.ready <= 1'b1;
         ready_hold   <= 0;
      end else if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_ch.ready) begin
         rsp_ch.ready <= 1'b0;
         ready_hold   <= idle_length();
      end else begin
         rsp_ch.ready <= 1'b1;
         ready_hold   <= $urandom_range(0, 8);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // One request beat, with a random idle stretch in front unless steady; returns at the accepting edge
   task automatic send_fraction_pair(logic kind, num_type an, den_type ad, num_type bn,
                                     den_type bd);
      int gap;
      gap = steady ? 0 : idle_length();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind  <= kind;
      req_ch.a_num <= an;
      req_ch.a_den <= ad;
      req_ch.b_num <= bn;
      req_ch.b_den <= bd;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   initial begin : stimulus
      int   r;
      int   g;
      logic kind;
      req_ch.valid = 1'b0;
      req_ch.kind  = OP_ADD;
      req_ch.a_num = '0;
      req_ch.a_den = den_type'(1);
      req_ch.b_num = '0;
      req_ch.b_den = den_type'(1);
      rsp_ch.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: plain cases, extremes, zero numerators, zero denominators
      send_fraction_pair(OP_ADD, num_type'(1), den_type'(2), num_type'(1), den_type'(3));
      send_fraction_pair(OP_MUL, num_type'(2), den_type'(3), num_type'(3), den_type'(4));
      send_fraction_pair(OP_ADD, num_type'(-1), den_type'(2), num_type'(1), den_type'(3));
      send_fraction_pair(OP_MUL, num_type'(-5), den_type'(6), num_type'(3), den_type'(10));
      send_fraction_pair(OP_ADD, NUM_MIN, DEN_MAX, NUM_MIN, DEN_MAX);
      send_fraction_pair(OP_ADD, NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX);
      send_fraction_pair(OP_ADD, NUM_MIN, den_type'(1), NUM_MIN, den_type'(1));
      send_fraction_pair(OP_ADD, NUM_MAX, den_type'(1), NUM_MAX, den_type'(1));
      send_fraction_pair(OP_ADD, NUM_MIN, DEN_MAX, NUM_MIN, den_type'(32766));
      send_fraction_pair(OP_MUL, NUM_MIN, den_type'(1), NUM_MIN, den_type'(1));
      send_fraction_pair(OP_MUL, NUM_MIN, den_type'(1), NUM_MAX, den_type'(1));
      send_fraction_pair(OP_MUL, num_type'(1), DEN_MAX, num_type'(1), DEN_MAX);
      send_fraction_pair(OP_ADD, num_type'(1), den_type'(16384), num_type'(1),
                         den_type'(16384));
      send_fraction_pair(OP_MUL, num_type'(-1), den_type'(1), num_type'(-1), den_type'(1));
      send_fraction_pair(OP_ADD, num_type'(0), den_type'(5), num_type'(0), den_type'(7));
      send_fraction_pair(OP_MUL, num_type'(0), den_type'(3), num_type'(5), den_type'(7));
      send_fraction_pair(OP_ADD, num_type'(3), den_type'(4), num_type'(-3), den_type'(4));
      send_fraction_pair(OP_ADD, num_type'(1), den_type'(0), num_type'(1), den_type'(2));
      send_fraction_pair(OP_MUL, num_type'(3), den_type'(5), num_type'(2), den_type'(0));
      send_fraction_pair(OP_ADD, NUM_MIN, den_type'(0), NUM_MAX, den_type'(0));
      send_fraction_pair(OP_MUL, num_type'(0), den_type'(0), num_type'(0), den_type'(5));
      send_fraction_pair(OP_MUL, NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX);

      // Random: broad values, small values, and operands that share factors
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 60 == 0)
            steady <= ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 1) ? OP_MUL : OP_ADD;
         r = $urandom_range(0, 99);
         if (r < 80) begin
            send_fraction_pair(kind, pick_num(), pick_den(), pick_num(), pick_den());
         end else begin
            g = $urandom_range(2, 200);
            send_fraction_pair(kind,
               num_type'(g * (int'($urandom_range(0, 200)) - 100)),
               den_type'(g * int'($urandom_range(1, 100))),
               num_type'(g * (int'($urandom_range(0, 200)) - 100)),
               den_type'(g * int'($urandom_range(1, 100))));
         end
      end

      // Drain
      req_ch.valid <= 1'b0;
      steady       <= 1'b0;
      @(posedge clock);
      while (fractions_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && fractions_pending == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: files.f
rtl/core/rarm_pkg.sv
rtl/core/rarm_req_if.sv
rtl/core/rarm_rsp_if.sv
rtl/core/rarm_fifo.sv
rtl/core/rarm_front.sv
rtl/core/rarm_back.sv
rtl/core/rational_add_multiply_reduce_top.sv
tb/rarm_result_checker.sv
tb/rational_add_multiply_reduce_top_test.sv
